>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros sampled on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define WSFP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that a condition implies another one on the following clock edge.
`define WSFP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/wsfp_pkg.sv
// ----------------------------------------------------------------------------
// wsfp_pkg
// Phase codes, header constants and the result record of the frame parser.
// ----------------------------------------------------------------------------
package wsfp_pkg;

  typedef enum logic [4:0] {
    PH_FIRST   = 5'b00001,
    PH_SECOND  = 5'b00010,
    PH_EXT     = 5'b00100,
    PH_MASK    = 5'b01000,
    PH_PAYLOAD = 5'b10000
  } phase_t;

  localparam logic [6:0] LEN_EXT16   = 7'd126;
  localparam logic [6:0] LEN_EXT64   = 7'd127;
  localparam logic [3:0] OPCODE_TEXT = 4'd1;
  localparam logic [2:0] EXT16_LEFT  = 3'd1;
  localparam logic [2:0] EXT64_LEFT  = 3'd7;
  localparam logic [1:0] KEY_LEFT    = 2'd3;

  typedef struct packed {
    logic        is_payload;
    logic [7:0]  payload_byte;
    logic        header_done;
    logic        frame_last;
    logic        fin_flag;
    logic [3:0]  frame_opcode;
    logic        masked;
    logic [63:0] payload_length;
    logic [31:0] masking_key;
  } res_t;

  typedef struct packed {
    logic valid;
    logic advance;
  } flow_t;

endpackage

>>> sv/websocket_frame_header_parser.sv
// ----------------------------------------------------------------------------
// websocket_frame_header_parser
// Byte-wide WebSocket frame deframer: header decode and payload byte marking.
//
//   channel  | direction | handshake                   | payload
//   data     | in        | data_valid / data_stall     | data_byte
//   result   | out       | result_valid / result_stall | is_payload .. masking_key
//
// One byte per clock sustained while result_stall is low; an input byte passes
// through the input register and then the result register to reach the result.
// rst is synchronous: decode returns to the first header byte, opcode text.
// A stalled result holds; the input register still takes one more byte, and
// data_stall rises only while both registers are full and result_stall is high.
// ----------------------------------------------------------------------------
module websocket_frame_header_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        data_valid,
  output logic        data_stall,
  input  logic [7:0]  data_byte,
  output logic        result_valid,
  input  logic        result_stall,
  output logic        is_payload,
  output logic [7:0]  payload_byte,
  output logic        header_done,
  output logic        frame_last,
  output logic        fin_flag,
  output logic [3:0]  frame_opcode,
  output logic        masked,
  output logic [63:0] payload_length,
  output logic [31:0] masking_key
);

  wsfp_pkg::flow_t flow;
  wsfp_pkg::res_t  res;
  wsfp_pkg::res_t  res_q;
  logic [7:0]      byte_q;
  logic            advance;

  wsfp_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .data_valid (data_valid),
    .data_stall (data_stall),
    .data_byte  (data_byte),
    .advance    (advance),
    .flow       (flow),
    .byte_q     (byte_q)
  );

  wsfp_core u_core (
    .clk    (clk),
    .rst    (rst),
    .flow   (flow),
    .byte_q (byte_q),
    .res    (res)
  );

  wsfp_out_stage u_out (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (flow.valid),
    .res          (res),
    .advance      (advance),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .res_q        (res_q)
  );

  assign is_payload     = res_q.is_payload;
  assign payload_byte   = res_q.payload_byte;
  assign header_done    = res_q.header_done;
  assign frame_last     = res_q.frame_last;
  assign fin_flag       = res_q.fin_flag;
  assign frame_opcode   = res_q.frame_opcode;
  assign masked         = res_q.masked;
  assign payload_length = res_q.payload_length;
  assign masking_key    = res_q.masking_key;

endmodule

>>> sv/wsfp_in_stage.sv
// ----------------------------------------------------------------------------
// wsfp_in_stage
// Input register: capture one byte per transaction and hold it until used.
// ----------------------------------------------------------------------------
module wsfp_in_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                data_valid,
  output logic                data_stall,
  input  logic [7:0]          data_byte,
  input  logic                advance,
  output wsfp_pkg::flow_t     flow,
  output logic [7:0]          byte_q
);

  logic valid_q;
  logic load;

  assign data_stall   = valid_q && !advance;
  assign load         = data_valid && !data_stall;
  assign flow.valid   = valid_q;
  assign flow.advance = advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (advance) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_q <= data_byte;
    end
  end

endmodule

>>> sv/wsfp_core.sv
// ----------------------------------------------------------------------------
// wsfp_core
// Header decode state: phase, length, mask key and payload byte countdown.
// ----------------------------------------------------------------------------
module wsfp_core (
  input  logic                clk,
  input  logic                rst,
  input  wsfp_pkg::flow_t     flow,
  input  logic [7:0]          byte_q,
  output wsfp_pkg::res_t      res
);

  wsfp_pkg::phase_t phase, phase_next;
  logic [2:0]  ext_left, ext_left_next;
  logic [1:0]  key_left, key_left_next;
  logic        fin, fin_next;
  logic [3:0]  opcode, opcode_next;
  logic        mask_flag, mask_flag_next;
  logic [63:0] length, length_next;
  logic [31:0] key, key_next;
  logic [63:0] bytes_left, bytes_left_next;
  logic        len_known;
  logic        hdr_end;
  logic        is_pl;
  logic        hdone;
  logic        last;
  logic        fire;

  assign fire = flow.valid && flow.advance;

  always_comb begin
    phase_next      = phase;
    ext_left_next   = ext_left;
    key_left_next   = key_left;
    fin_next        = fin;
    opcode_next     = opcode;
    mask_flag_next  = mask_flag;
    length_next     = length;
    key_next        = key;
    bytes_left_next = bytes_left;
    len_known       = 1'b0;
    hdr_end         = 1'b0;
    is_pl           = 1'b0;
    hdone           = 1'b0;
    last            = 1'b0;

    unique case (phase)
      wsfp_pkg::PH_SECOND: begin
        mask_flag_next = byte_q[7];
        key_next       = 32'd0;
        if (byte_q[6:0] == wsfp_pkg::LEN_EXT16) begin
          length_next   = 64'd0;
          ext_left_next = wsfp_pkg::EXT16_LEFT;
          phase_next    = wsfp_pkg::PH_EXT;
        end else if (byte_q[6:0] == wsfp_pkg::LEN_EXT64) begin
          length_next   = 64'd0;
          ext_left_next = wsfp_pkg::EXT64_LEFT;
          phase_next    = wsfp_pkg::PH_EXT;
        end else begin
          length_next = {57'd0, byte_q[6:0]};
          len_known   = 1'b1;
        end
      end
      wsfp_pkg::PH_EXT: begin
        length_next = {length[55:0], byte_q};
        if (ext_left == 3'd0) begin
          len_known = 1'b1;
        end else begin
          ext_left_next = ext_left - 3'd1;
        end
      end
      wsfp_pkg::PH_MASK: begin
        key_next = {key[23:0], byte_q};
        if (key_left == 2'd0) begin
          hdone   = 1'b1;
          hdr_end = 1'b1;
        end else begin
          key_left_next = key_left - 2'd1;
        end
      end
      wsfp_pkg::PH_PAYLOAD: begin
        is_pl           = 1'b1;
        bytes_left_next = bytes_left - 64'd1;
        if (bytes_left == 64'd1) begin
          last       = 1'b1;
          phase_next = wsfp_pkg::PH_FIRST;
        end
      end
      default: begin
        fin_next       = byte_q[7];
        opcode_next    = byte_q[3:0];
        mask_flag_next = 1'b0;
        length_next    = 64'd0;
        key_next       = 32'd0;
        phase_next     = wsfp_pkg::PH_SECOND;
      end
    endcase

    if (len_known) begin
      if (mask_flag_next) begin
        key_left_next = wsfp_pkg::KEY_LEFT;
        phase_next    = wsfp_pkg::PH_MASK;
      end else begin
        hdone   = 1'b1;
        hdr_end = 1'b1;
      end
    end

    if (hdr_end) begin
      bytes_left_next = length_next;
      if (length_next == 64'd0) begin
        last       = 1'b1;
        phase_next = wsfp_pkg::PH_FIRST;
      end else begin
        phase_next = wsfp_pkg::PH_PAYLOAD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= wsfp_pkg::PH_FIRST;
      ext_left   <= 3'd0;
      key_left   <= 2'd0;
      fin        <= 1'b0;
      opcode     <= wsfp_pkg::OPCODE_TEXT;
      mask_flag  <= 1'b0;
      length     <= 64'd0;
      key        <= 32'd0;
      bytes_left <= 64'd0;
    end else if (fire) begin
      phase      <= phase_next;
      ext_left   <= ext_left_next;
      key_left   <= key_left_next;
      fin        <= fin_next;
      opcode     <= opcode_next;
      mask_flag  <= mask_flag_next;
      length     <= length_next;
      key        <= key_next;
      bytes_left <= bytes_left_next;
    end
  end

  always_comb begin
    res.is_payload     = is_pl;
    res.payload_byte   = is_pl ? byte_q : 8'd0;
    res.header_done    = hdone;
    res.frame_last     = last;
    res.fin_flag       = fin_next;
    res.frame_opcode   = opcode_next;
    res.masked         = mask_flag_next;
    res.payload_length = length_next;
    res.masking_key    = key_next;
  end

endmodule

>>> sv/wsfp_out_stage.sv
// ----------------------------------------------------------------------------
// wsfp_out_stage
// Result register: hold one result transaction until the consumer takes it.
// ----------------------------------------------------------------------------
module wsfp_out_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  wsfp_pkg::res_t      res,
  output logic                advance,
  output logic                result_valid,
  input  logic                result_stall,
  output wsfp_pkg::res_t      res_q
);

  logic valid_q;

  assign advance      = in_valid && (!valid_q || !result_stall);
  assign result_valid = valid_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (advance) begin
      valid_q <= 1'b1;
    end else if (!result_stall) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= res;
    end
  end

endmodule

>>> sv/wsfp_checker.sv
// ----------------------------------------------------------------------------
// wsfp_checker
// Port-level checks on the frame parser, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wsfp_checker (
  input logic        clk,
  input logic        rst,
  input logic        result_valid,
  input logic        result_stall,
  input logic        is_payload,
  input logic [7:0]  payload_byte,
  input logic        header_done,
  input logic        frame_last,
  input logic        fin_flag,
  input logic [3:0]  frame_opcode,
  input logic        masked,
  input logic [63:0] payload_length,
  input logic [31:0] masking_key
);

  logic [112:0] res_bits;

  assign res_bits = {is_payload, payload_byte, header_done, frame_last, fin_flag,
                     frame_opcode, masked, payload_length, masking_key};

  `WSFP_ASSERT_NEXT(a_hold_valid, result_valid && result_stall, result_valid, "result valid dropped under stall")
  `WSFP_ASSERT_NEXT(a_hold_data, result_valid && result_stall, $stable(res_bits), "stalled result changed")
  `WSFP_ASSERT(a_pl_zero, (result_valid && !is_payload) |-> (payload_byte == 8'd0), "non-payload byte not zero")
  `WSFP_ASSERT(a_hdr_not_pl, (result_valid && header_done) |-> !is_payload, "header end marked as payload")
  `WSFP_ASSERT(a_reset_empty, $past(rst) |-> !result_valid, "result valid right after reset")

endmodule

bind websocket_frame_header_parser wsfp_checker u_wsfp_checker (.*);
